// ===== hw/rtl/itod_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itod_pkg: shared types and constants
// Constants and the command/status words between the top level and the
// BCD converter of the integer to decimal text block.
// ----------------------------------------------------------------------------
package itod_pkg;

    // default operand width
    localparam int VALUE_WIDTH_DEF = 32;

    // BCD digit width
    localparam int DIGIT_W = 4;

    // ASCII codes
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    // command word to the converter
    typedef struct packed {
        logic start;      // load magnitude, clear digits, begin conversion
        logic shift_dig;  // drop the leading digit
    } dab_cmd_t;

    // status word from the converter
    typedef struct packed {
        logic               busy;
        logic [DIGIT_W-1:0] top_digit;
    } dab_stat_t;

endpackage

// ===== hw/rtl/itod_dabble.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itod_dabble: bit-serial binary to BCD converter
// Shift-and-add-3 conversion, one magnitude bit per cycle. The digit
// register then shifts out one digit at a time, leading digit first.
// ----------------------------------------------------------------------------
module itod_dabble #(
    parameter int VALUE_WIDTH = itod_pkg::VALUE_WIDTH_DEF,
    parameter int NUM_DIGITS  = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  itod_pkg::dab_cmd_t      cmd,
    input  logic [VALUE_WIDTH-1:0]  mag,
    output itod_pkg::dab_stat_t     stat
);

    localparam int BCD_W = NUM_DIGITS * itod_pkg::DIGIT_W;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [BCD_W-1:0]       bcd_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    // next state
    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        if (cmd.start)
        begin
            bin_next = mag;
            bcd_next = '0;
            cnt_next = CNT_W'(VALUE_WIDTH);
        end
        else if (cnt_reg != '0)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
        else if (cmd.shift_dig)
        begin
            bcd_next = {bcd_reg[BCD_W-itod_pkg::DIGIT_W-1:0], {itod_pkg::DIGIT_W{1'b0}}};
        end
    end

    // control count under reset; data words need none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stat.busy      = (cnt_reg != '0);
    assign stat.top_digit = bcd_reg[BCD_W-1 -: itod_pkg::DIGIT_W];

endmodule

// ===== hw/rtl/int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// Operation: the word is loaded and converted by bit-serial BCD conversion
//   (the shift-add-3 register), leading zero digits are skipped one by one,
//   then one character per cycle leaves on the output register, unless stalled.
// A new word is taken only after the last character of the previous word
//   has entered the output register.
// Reset: asynchronous, active low; signed_mode returns to 1, output empty.
// ----------------------------------------------------------------------------
// int_to_decimal_ascii: integer to decimal ASCII text
// Converts one word to its decimal text, leading digit first, one
// character per output word, with last on the final character.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = itod_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    // input channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VALUE_WIDTH-1:0] value,
    // output channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             char_out,
    output logic                   last
);

    // decimal digits of the largest unsigned value: floor(W*log10(2))+1
    localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int DCNT_W     = $clog2(NUM_DIGITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t              state_reg, state_next;
    logic                signed_mode_reg, signed_mode_next;
    logic                neg_reg, neg_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          char_reg, char_next;
    logic                last_reg, last_next;

    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic                   slot_free;
    itod_pkg::dab_cmd_t     dab_cmd;
    itod_pkg::dab_stat_t    dab_stat;

    // sign and magnitude of the incoming word
    assign in_neg = signed_mode_reg & value[VALUE_WIDTH-1];
    assign in_mag = in_neg ? VALUE_WIDTH'(~value + 1'b1) : value;

    // output register can take a character
    assign slot_free = !out_valid_reg || out_ready;

    // control
    always_comb
    begin
        state_next       = state_reg;
        signed_mode_next = cfg_we ? cfg_wdata : signed_mode_reg;
        neg_next         = neg_reg;
        dcnt_next        = dcnt_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        char_next        = char_reg;
        last_next        = last_reg;
        dab_cmd          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dab_cmd.start = 1'b1;
                    neg_next      = in_neg;
                    dcnt_next     = DCNT_W'(NUM_DIGITS);
                    state_next    = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (!dab_stat.busy)
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if (dab_stat.top_digit == '0 && dcnt_reg > DCNT_W'(1))
                begin
                    dab_cmd.shift_dig = 1'b1;
                    dcnt_next         = dcnt_reg - 1'b1;
                end
                else if (neg_reg)
                    state_next = ST_SIGN;
                else
                    state_next = ST_DIGITS;
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = itod_pkg::ASCII_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (slot_free)
                begin
                    out_valid_next    = 1'b1;
                    char_next         = itod_pkg::ASCII_ZERO + {4'd0, dab_stat.top_digit};
                    last_next         = (dcnt_reg == DCNT_W'(1));
                    dab_cmd.shift_dig = 1'b1;
                    dcnt_next         = dcnt_reg - 1'b1;
                    if (dcnt_reg == DCNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            signed_mode_reg <= 1'b1;
            neg_reg         <= 1'b0;
            dcnt_reg        <= '0;
            out_valid_reg   <= 1'b0;
            char_reg        <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            signed_mode_reg <= signed_mode_next;
            neg_reg         <= neg_next;
            dcnt_reg        <= dcnt_next;
            out_valid_reg   <= out_valid_next;
            char_reg        <= char_next;
            last_reg        <= last_next;
        end
    end

    // bit-serial BCD converter
    itod_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (dab_cmd),
        .mag   (in_mag),
        .stat  (dab_stat)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    // only a minus sign or a decimal digit leaves the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg == itod_pkg::ASCII_MINUS ||
                           (char_reg >= itod_pkg::ASCII_ZERO &&
                            char_reg <= itod_pkg::ASCII_NINE)))
        else $error("output character out of range");

    // a sign is always followed by digits
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && char_reg == itod_pkg::ASCII_MINUS) |-> !last_reg)
        else $error("minus sign flagged last");

    // converter is idle whenever a new word may enter
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !dab_stat.busy)
        else $error("converter busy while idle");

    // digits remain to be sent while emitting
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGITS || state_reg == ST_SIGN) |-> (dcnt_reg != '0))
        else $error("digit count exhausted");

    // accepted word starts the converter on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> dab_stat.busy)
        else $error("conversion did not start");
`endif

endmodule
